### design/sha1_pkg.sv
package sha1_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int ROUNDS      = 80;
    localparam int HASH_WORDS  = 5;
    localparam int LEN_BYTE_AT = 56;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic REQ_DATA   = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    localparam logic [1:0] STATUS_DIGEST   = 2'd0;
    localparam logic [1:0] STATUS_AFTER    = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

    localparam logic [31:0] H_INIT [HASH_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_FINAL,
        ST_EMIT
    } state_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

endpackage

### design/sha1_ram.sv
module sha1_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/sha1_stream_hasher_top.sv
// Channel   Direction  tdata (low bit up)                tuser        tlast
// s_axis    in         data_byte[7:0]                    req_type     -
// m_axis    out        word_index[2:0], digest_word      status[1:0]  last
//
// A data byte is taken only while idle; the 64th byte of a block starts a compression
// (reading the block memory byte by byte, 80 rounds, one chaining addition) during
// which no word is taken. A finish after a finish sends the same five words again.
// A first finish writes the padding one byte per cycle up to the end of the block,
// then compresses one or two blocks and sends five words, one per unstalled cycle.
// Reset (rst_n low) clears the control state; the block memory holds no reset value.
// A stalled output holds its word and no input word is taken until it leaves.
module sha1_stream_hasher_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  logic        s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // word_index[2:0], digest_word[34:3], zeros
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    output logic        m_axis_tlast
);
    import sha1_pkg::*;

    state_t       state_reg, state_next;
    logic [5:0]   fill_reg, fill_next;
    logic [63:0]  len_reg, len_next;
    logic         fin_reg, fin_next;
    logic [31:0]  h_reg [HASH_WORDS];
    logic [31:0]  h_next [HASH_WORDS];
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]  a_next, b_next, c_next, d_next, e_next;
    logic [511:0] w_reg, w_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic [5:0]   pos_reg, pos_next;
    logic         first_reg, first_next;
    logic         lenblk_reg, lenblk_next;
    logic         padact_reg, padact_next;
    logic [2:0]   idx_reg, idx_next;
    logic         ov_reg, ov_next;
    logic [1:0]   ost_reg, ost_next;
    logic [2:0]   oidx_reg, oidx_next;
    logic [31:0]  oword_reg, oword_next;
    logic         olast_reg, olast_next;

    logic         accept, out_free;
    logic         ram_we;
    logic [5:0]   ram_waddr, ram_raddr;
    logic [7:0]   ram_wdata, ram_rdata;
    logic [7:0]   pad_byte;
    logic [63:0]  len_shift;
    logic [31:0]  f_val, k_val, w_new, t_val;

    sha1_ram #(.WIDTH(8), .DEPTH(BLOCK_BYTES)) u_block (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        out_free      = !ov_reg || m_axis_tready;
        s_axis_tready = (state_reg == ST_IDLE) && out_free;
        accept        = s_axis_tvalid && s_axis_tready;
        len_shift     = len_reg >> {~pos_reg[2:0], 3'b000};
        if (first_reg)
        begin
            pad_byte = PAD_MARK;
        end
        else if (lenblk_reg && (pos_reg >= 6'(LEN_BYTE_AT)))
        begin
            pad_byte = len_shift[7:0];
        end
        else
        begin
            pad_byte = 8'h00;
        end
        ram_raddr = cnt_reg[5:0];
        ram_we    = 1'b0;
        ram_waddr = fill_reg;
        ram_wdata = s_axis_tdata;
        if (state_reg == ST_PAD)
        begin
            ram_we    = 1'b1;
            ram_waddr = pos_reg;
            ram_wdata = pad_byte;
        end
        else if (accept && (s_axis_tuser == REQ_DATA) && !fin_reg && !(&len_reg[63:3]))
        begin
            ram_we = 1'b1;
        end
        if (cnt_reg < 7'd20)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K0;
        end
        else if (cnt_reg < 7'd40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K1;
        end
        else if (cnt_reg < 7'd60)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K3;
        end
        w_new = rotl(w_reg[95:64] ^ w_reg[255:224] ^ w_reg[447:416] ^ w_reg[511:480],
                     5'd1);
        t_val = rotl(a_reg, 5'd5) + f_val + e_reg + w_reg[511:480] + k_val;
    end

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        len_next    = len_reg;
        fin_next    = fin_reg;
        h_next      = h_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        d_next      = d_reg;
        e_next      = e_reg;
        w_next      = w_reg;
        cnt_next    = cnt_reg;
        pos_next    = pos_reg;
        first_next  = first_reg;
        lenblk_next = lenblk_reg;
        padact_next = padact_reg;
        idx_next    = idx_reg;
        ov_next     = ov_reg && !m_axis_tready;
        ost_next    = ost_reg;
        oidx_next   = oidx_reg;
        oword_next  = oword_reg;
        olast_next  = olast_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_axis_tuser == REQ_DATA)
                    begin
                        if (fin_reg || (&len_reg[63:3]))
                        begin
                            ov_next    = 1'b1;
                            ost_next   = fin_reg ? STATUS_AFTER : STATUS_TOO_LONG;
                            oidx_next  = 3'd0;
                            oword_next = 32'd0;
                            olast_next = 1'b1;
                        end
                        else
                        begin
                            fill_next = fill_reg + 6'd1;
                            len_next  = len_reg + 64'd8;
                            if (&fill_reg)
                            begin
                                state_next  = ST_LOAD;
                                cnt_next    = 7'd0;
                                padact_next = 1'b0;
                            end
                        end
                    end
                    else if (fin_reg)
                    begin
                        state_next = ST_EMIT;
                        idx_next   = 3'd0;
                    end
                    else
                    begin
                        state_next  = ST_PAD;
                        pos_next    = fill_reg;
                        first_next  = 1'b1;
                        lenblk_next = fill_reg < 6'(LEN_BYTE_AT);
                        padact_next = 1'b1;
                    end
                end
            end
            ST_PAD:
            begin
                first_next = 1'b0;
                pos_next   = pos_reg + 6'd1;
                if (&pos_reg)
                begin
                    state_next = ST_LOAD;
                    cnt_next   = 7'd0;
                end
            end
            ST_LOAD:
            begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg != 7'd0)
                begin
                    w_next = {w_reg[503:0], ram_rdata};
                end
                if (cnt_reg == 7'(BLOCK_BYTES))
                begin
                    state_next = ST_ROUND;
                    cnt_next   = 7'd0;
                    a_next     = h_reg[0];
                    b_next     = h_reg[1];
                    c_next     = h_reg[2];
                    d_next     = h_reg[3];
                    e_next     = h_reg[4];
                end
            end
            ST_ROUND:
            begin
                a_next   = t_val;
                b_next   = a_reg;
                c_next   = rotl(b_reg, 5'd30);
                d_next   = c_reg;
                e_next   = d_reg;
                w_next   = {w_reg[479:0], w_new};
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'(ROUNDS - 1))
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                h_next[0] = h_reg[0] + a_reg;
                h_next[1] = h_reg[1] + b_reg;
                h_next[2] = h_reg[2] + c_reg;
                h_next[3] = h_reg[3] + d_reg;
                h_next[4] = h_reg[4] + e_reg;
                fill_next = 6'd0;
                if (!padact_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!lenblk_reg)
                begin
                    state_next  = ST_PAD;
                    pos_next    = 6'd0;
                    first_next  = 1'b0;
                    lenblk_next = 1'b1;
                end
                else
                begin
                    state_next  = ST_EMIT;
                    idx_next    = 3'd0;
                    fin_next    = 1'b1;
                    len_next    = 64'd0;
                    padact_next = 1'b0;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ost_next   = STATUS_DIGEST;
                    oidx_next  = idx_reg;
                    oword_next = h_reg[idx_reg];
                    olast_next = idx_reg == 3'(HASH_WORDS - 1);
                    idx_next   = idx_reg + 3'd1;
                    if (idx_reg == 3'(HASH_WORDS - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= 6'd0;
            len_reg    <= 64'd0;
            fin_reg    <= 1'b0;
            h_reg      <= H_INIT;
            cnt_reg    <= 7'd0;
            pos_reg    <= 6'd0;
            first_reg  <= 1'b0;
            lenblk_reg <= 1'b0;
            padact_reg <= 1'b0;
            idx_reg    <= 3'd0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            len_reg    <= len_next;
            fin_reg    <= fin_next;
            h_reg      <= h_next;
            cnt_reg    <= cnt_next;
            pos_reg    <= pos_next;
            first_reg  <= first_next;
            lenblk_reg <= lenblk_next;
            padact_reg <= padact_next;
            idx_reg    <= idx_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        c_reg     <= c_next;
        d_reg     <= d_next;
        e_reg     <= e_next;
        w_reg     <= w_next;
        ost_reg   <= ost_next;
        oidx_reg  <= oidx_next;
        oword_reg <= oword_next;
        olast_reg <= olast_next;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {5'd0, oword_reg, oidx_reg};
    assign m_axis_tuser  = ost_reg;
    assign m_axis_tlast  = olast_reg;

endmodule

### tb/tb.sv
module tb;

    import sha1_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  word_index;
        logic [31:0] digest_word;
        logic        last;
    } hash_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    hash_result_t digest_words_q[$];
    logic [7:0]   msg_block[BLOCK_BYTES];
    int           msg_fill;
    logic [63:0]  msg_bits;
    logic [31:0]  chain[HASH_WORDS];
    logic         msg_closed;
    bit           calm = 1'b0;
    int           errors = 0;
    int           idle_cycles = 0;

    sha1_stream_hasher_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic logic [31:0] rot_left(logic [31:0] x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void sha1_compress();
        logic [31:0] w[80];
        logic [31:0] a, b, c, d, e, f, t, k;
        for (int i = 0; i < 16; i++)
        begin
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        end
        for (int i = 16; i < 80; i++)
        begin
            w[i] = rot_left(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        end
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
        for (int i = 0; i < 80; i++)
        begin
            if (i < 20)
            begin
                f = (b & c) | (~b & d);
                k = K0;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d;
                k = K1;
            end
            else if (i < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K3;
            end
            t = rot_left(a, 5) + f + e + w[i] + k;
            e = d; d = c; c = rot_left(b, 30); b = a; a = t;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
        msg_fill = 0;
    endfunction

    function automatic void push_error(logic [1:0] code);
        hash_result_t r;
        r.status = code;
        r.word_index = 3'd0;
        r.digest_word = 32'd0;
        r.last = 1'b1;
        digest_words_q.push_back(r);
    endfunction

    function automatic void predict_request(logic req, logic [7:0] data);
        hash_result_t r;
        int pos;
        if (req == REQ_DATA)
        begin
            if (msg_closed)
            begin
                push_error(STATUS_AFTER);
            end
            else if (~msg_bits < 64'd8)
            begin
                push_error(STATUS_TOO_LONG);
            end
            else
            begin
                msg_block[msg_fill] = data;
                msg_fill++;
                msg_bits += 64'd8;
                if (msg_fill >= BLOCK_BYTES)
                begin
                    sha1_compress();
                end
            end
            return;
        end
        if (!msg_closed)
        begin
            pos = msg_fill;
            msg_block[pos] = PAD_MARK;
            pos++;
            if (pos > LEN_BYTE_AT)
            begin
                for (int i = pos; i < BLOCK_BYTES; i++)
                begin
                    msg_block[i] = 8'h00;
                end
                sha1_compress();
                pos = 0;
            end
            for (int i = pos; i < LEN_BYTE_AT; i++)
            begin
                msg_block[i] = 8'h00;
            end
            for (int i = 0; i < 8; i++)
            begin
                msg_block[LEN_BYTE_AT + i] = msg_bits[63 - 8*i -: 8];
            end
            sha1_compress();
            msg_closed = 1'b1;
            msg_bits = 64'd0;
        end
        for (int i = 0; i < HASH_WORDS; i++)
        begin
            r.status = STATUS_DIGEST;
            r.word_index = 3'(i);
            r.digest_word = chain[i];
            r.last = (i == HASH_WORDS - 1);
            digest_words_q.push_back(r);
        end
    endfunction

    task automatic send_word(logic req, logic [7:0] data);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= req;
        s_axis_tdata <= data;
        do
        begin
            @(posedge clk);
        end
        while (!(s_axis_tvalid && s_axis_tready));
        predict_request(req, data);
    endtask

    task automatic test_directed_bytes();
        send_word(REQ_DATA, 8'h00);
        send_word(REQ_DATA, 8'hFF);
        send_word(REQ_DATA, 8'h80);
        send_word(REQ_DATA, 8'h01);
        send_word(REQ_DATA, 8'hAA);
        send_word(REQ_DATA, 8'h55);
    endtask

    task automatic test_random_message();
        int len;
        len = 250 + $urandom_range(0, 63);
        for (int i = 0; i < len; i++)
        begin
            send_word(REQ_DATA, 8'($urandom));
        end
    endtask

    task automatic test_finish();
        send_word(REQ_FINISH, 8'($urandom));
        s_axis_tvalid <= 1'b0;
        wait (digest_words_q.size() == 0);
        @(posedge clk);
    endtask

    task automatic test_repeat_finish();
        send_word(REQ_FINISH, 8'h00);
        send_word(REQ_FINISH, 8'hFF);
    endtask

    task automatic test_after_finish();
        send_word(REQ_DATA, 8'h00);
        send_word(REQ_DATA, 8'hFF);
        for (int i = 0; i < 14; i++)
        begin
            if (i == 7)
            begin
                calm = 1'b1;
            end
            send_word($urandom_range(0, 3) == 0 ? REQ_FINISH : REQ_DATA, 8'($urandom));
        end
        s_axis_tvalid <= 1'b0;
    endtask

    initial
    begin
        msg_fill = 0;
        msg_bits = 64'd0;
        msg_closed = 1'b0;
        for (int i = 0; i < HASH_WORDS; i++)
        begin
            chain[i] = H_INIT[i];
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_bytes();
        test_random_message();
        test_finish();
        test_repeat_finish();
        test_after_finish();
        wait (digest_words_q.size() == 0);
        repeat (400) @(posedge clk);
        if (errors == 0 && digest_words_q.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (digest_words_q.size() == 0)
            begin
                $error("unexpected word: status %0d data %h", m_axis_tuser, m_axis_tdata);
                errors++;
            end
            else
            begin
                hash_result_t e;
                e = digest_words_q.pop_front();
                if (m_axis_tuser !== e.status)
                begin
                    $error("status: expected %0d, got %0d", e.status, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata[2:0] !== e.word_index)
                begin
                    $error("word_index: expected %0d, got %0d", e.word_index, m_axis_tdata[2:0]);
                    errors++;
                end
                if (m_axis_tdata[34:3] !== e.digest_word)
                begin
                    $error("digest_word: expected %h, got %h", e.digest_word,
                           m_axis_tdata[34:3]);
                    errors++;
                end
                if (m_axis_tlast !== e.last)
                begin
                    $error("last: expected %0d, got %0d", e.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= 3000)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

endmodule
